// ----- rtl/dpc_pkg.sv -----
// Shared types and constants for the DAG path count / length sum block.
// No dependencies; imported by every module of the block except dpc_ram.
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int unsigned MODV      = 10000;
    localparam int unsigned NODE_W    = 10;
    localparam int unsigned LEN_W     = 14;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 14;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 2'd0,
        KIND_COMPUTE = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA  = 2'd2;

    typedef enum logic [4:0] {
        S_INIT,      // sweep node link heads to empty
        S_IDLE,
        S_ADD_WR,
        S_CLR_NODE,  // zero pending/paths/length
        S_CNT_RD,
        S_CNT_NODE,
        S_CNT_WR,
        S_SEED_RD,
        S_SEED_WR,
        S_POP,
        S_POP_WAIT,
        S_FIRST,
        S_EDGE_CHK,
        S_EDGE_DAT,
        S_XDAT,
        S_YDAT,
        S_MUL,
        S_ANS_RD,
        S_ANS_GO,
        S_ANS_WAIT,
        S_ANS_HOLD
    } st_t;

    // request to the modular multiply-add unit
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [LEN_W:0]   addend;
    } mm_req_t;

    // reduce a value below 2*MODV into 0..MODV-1
    function automatic logic [LEN_W-1:0] mod_once(input logic [LEN_W:0] v);
        logic [LEN_W:0] lim;
        lim = (LEN_W+1)'(MODV);
        if (v >= lim) begin
            return LEN_W'(v - lim);
        end
        return LEN_W'(v);
    endfunction

endpackage

// ----- rtl/dpc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ----- rtl/dpc_modmul.sv -----
// Three-stage (a*b + addend) mod 10000 unit, reciprocal-multiply reduction.
// Depends on dpc_pkg.
`timescale 1ns / 1ps

module dpc_modmul
    import dpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mm_req_t          req,
    output logic             done,
    output logic [LEN_W-1:0] result
);

    // ceil(2^40 / 10000); quotient is exact or one high for p < 2^28
    localparam logic [26:0] RECIP = 27'd109951163;
    localparam int unsigned SHIFT = 40;

    logic [2:0]       vld_reg;
    logic [27:0]      prod_reg;
    logic [27:0]      prod2_reg;
    logic [LEN_W-1:0] quo_reg;
    logic [LEN_W-1:0] res_reg;
    logic [54:0]      scaled;
    logic [28:0]      diff;

    assign scaled = 55'(prod_reg) * 55'(RECIP);
    assign diff   = 29'(prod2_reg) - 29'(quo_reg) * 29'(MODV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], req.start};
        end
        prod_reg  <= 28'(req.a) * 28'(req.b) + 28'(req.addend);
        prod2_reg <= prod_reg;
        quo_reg   <= LEN_W'(scaled >> SHIFT);
        if (vld_reg[1]) begin
            // quotient one high leaves a negative remainder
            res_reg <= diff[28] ? LEN_W'(diff + 29'(MODV)) : LEN_W'(diff);
        end
    end

    assign done   = vld_reg[2];
    assign result = res_reg;

endmodule

// ----- rtl/dag_path_count_length_sum.sv -----
// Add-edge beat: accepted in S_IDLE, then written in S_ADD_WR; clear beat: a sweep of
// every node list head. Compute beat: a zero pass over node state, a pred count pass
// over the stored edges, the seed, then the walk, which reads source and destination
// state in turn through the node-state RAM's single read port; the answer is then
// formed in the multiply-add unit. Reset (aresetn low, sync): control cleared, then
// a sweep over all node list heads marks every node list empty before s_ready rises.
`timescale 1ns / 1ps

module dag_path_count_length_sum
    import dpc_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [NODE_W-1:0]    s_from_node,
    input  logic [NODE_W-1:0]    s_to_node,
    input  logic [LEN_W-1:0]     s_edge_length,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEN_W-1:0]     m_answer,
    output logic                 m_edges_dropped,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NIW = $clog2(MAX_NODES);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FW  = $clog2(MAX_EDGES + 1);
    localparam int TW  = $clog2(MAX_NODES + 1);
    localparam int EDW = NIW + LEN_W + FW;       // {dest, len, link}
    localparam int SW  = FW + 2 * LEN_W;         // {pending, paths, length}
    localparam logic [FW-1:0]  EMPTY     = FW'(MAX_EDGES);
    localparam logic [NIW-1:0] LAST_NODE = NIW'(MAX_NODES - 1);

    st_t state_reg, state_next;

    logic [NIW-1:0]    sweep_reg, sweep_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [NODE_W-1:0] start_reg, target_reg;
    logic [LEN_W-1:0]  extra_reg;
    logic [FW-1:0]     cnt_reg, cnt_next;
    logic [FW-1:0]     e_reg, e_next;
    logic [NIW-1:0]    x_reg, x_next;
    logic [NIW-1:0]    y_reg, y_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [FW-1:0]     link_reg, link_next;
    logic [LEN_W-1:0]  c_reg, c_next;
    logic [LEN_W-1:0]  l_reg, l_next;
    logic [FW-1:0]     ypend_reg, ypend_next;
    logic [LEN_W-1:0]  ypath_reg, ypath_next;
    logic [NIW-1:0]    from_reg, from_next;
    logic [NIW-1:0]    to_reg, to_next;
    logic [LEN_W-1:0]  elen_reg, elen_next;
    logic              mv_reg, mv_next;
    logic [LEN_W-1:0]  ans_reg, ans_next;
    logic              drop_reg, drop_next;

    // memory ports
    logic           em_we;
    logic [EIW-1:0] em_waddr, em_raddr;
    logic [EDW-1:0] em_wdata, em_rdata;
    logic           fm_we;
    logic [NIW-1:0] fm_waddr, fm_raddr;
    logic [FW-1:0]  fm_wdata, fm_rdata;
    logic           sm_we;
    logic [NIW-1:0] sm_waddr, sm_raddr;
    logic [SW-1:0]  sm_wdata, sm_rdata;
    logic           km_we;
    logic [NIW-1:0] km_waddr, km_raddr;
    logic [NIW-1:0] km_wdata, km_rdata;

    mm_req_t          mm_req;
    logic             mm_done;
    logic [LEN_W-1:0] mm_res;

    // decoded fields of the read ports
    logic [NIW-1:0]   ed_dest;
    logic [LEN_W-1:0] ed_len;
    logic [FW-1:0]    ed_link;
    logic [FW-1:0]    st_pend;
    logic [LEN_W-1:0] st_paths, st_len;

    assign ed_dest  = em_rdata[EDW-1 -: NIW];
    assign ed_len   = em_rdata[FW +: LEN_W];
    assign ed_link  = em_rdata[FW-1:0];
    assign st_pend  = sm_rdata[SW-1 -: FW];
    assign st_paths = sm_rdata[LEN_W +: LEN_W];
    assign st_len   = sm_rdata[LEN_W-1:0];

    logic from_ok, to_ok, start_ok, tgt_ok, store_full, sweep_last, out_free;
    logic stack_room, walk_more;

    assign from_ok    = 32'(s_from_node) < 32'(MAX_NODES);
    assign to_ok      = 32'(s_to_node) < 32'(MAX_NODES);
    assign start_ok   = 32'(start_reg) < 32'(MAX_NODES);
    assign tgt_ok     = 32'(target_reg) < 32'(MAX_NODES);
    assign store_full = 32'(fill_reg) >= 32'(MAX_EDGES);
    assign sweep_last = sweep_reg == LAST_NODE;
    assign out_free   = !mv_reg || m_ready;
    assign stack_room = 32'(top_reg) < 32'(MAX_NODES);
    assign walk_more  = e_reg < fill_reg;

    // edge store, node list heads, node state, ready stack
    dpc_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
        .raddr(em_raddr), .rdata(em_rdata)
    );
    dpc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_head_ram (
        .aclk(aclk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
        .raddr(fm_raddr), .rdata(fm_rdata)
    );
    dpc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk(aclk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
        .raddr(sm_raddr), .rdata(sm_rdata)
    );
    dpc_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES)) u_stack_ram (
        .aclk(aclk), .we(km_we), .waddr(km_waddr), .wdata(km_wdata),
        .raddr(km_raddr), .rdata(km_rdata)
    );

    dpc_modmul u_modmul (
        .aclk(aclk), .aresetn(aresetn), .req(mm_req), .done(mm_done), .result(mm_res)
    );

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     if (sweep_last) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        KIND_ADD: begin
                            if (from_ok && to_ok && !store_full) state_next = S_ADD_WR;
                        end
                        KIND_COMPUTE: state_next = S_CLR_NODE;
                        KIND_CLEAR:   state_next = S_INIT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR:   state_next = S_IDLE;
            S_CLR_NODE: begin
                if (sweep_last) state_next = (fill_reg == '0) ? S_SEED_RD : S_CNT_RD;
            end
            S_CNT_RD:   state_next = S_CNT_NODE;
            S_CNT_NODE: state_next = S_CNT_WR;
            S_CNT_WR:   state_next = (cnt_reg + 1'b1 == fill_reg) ? S_SEED_RD : S_CNT_RD;
            S_SEED_RD:  state_next = start_ok ? S_SEED_WR : S_POP;
            S_SEED_WR:  state_next = S_POP;
            S_POP:      state_next = (top_reg == '0) ? S_ANS_RD : S_POP_WAIT;
            S_POP_WAIT: state_next = S_FIRST;
            S_FIRST:    state_next = S_EDGE_CHK;
            S_EDGE_CHK: state_next = walk_more ? S_EDGE_DAT : S_POP;
            S_EDGE_DAT: state_next = S_XDAT;
            S_XDAT:     state_next = S_YDAT;
            S_YDAT:     state_next = S_MUL;
            S_MUL:      if (mm_done) state_next = S_EDGE_CHK;
            S_ANS_RD:   state_next = S_ANS_GO;
            S_ANS_GO:   state_next = S_ANS_WAIT;
            S_ANS_WAIT: if (mm_done) state_next = S_ANS_HOLD;
            S_ANS_HOLD: if (out_free) state_next = S_IDLE;
            default:    state_next = S_INIT;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        sweep_next = sweep_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        top_next   = top_reg;
        cnt_next   = cnt_reg;
        e_next     = e_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        len_next   = len_reg;
        link_next  = link_reg;
        c_next     = c_reg;
        l_next     = l_reg;
        ypend_next = ypend_reg;
        ypath_next = ypath_reg;
        from_next  = from_reg;
        to_next    = to_reg;
        elen_next  = elen_reg;
        ans_next   = ans_reg;
        drop_next  = drop_reg;
        mv_next    = mv_reg && !m_ready;

        em_we = 1'b0; em_waddr = '0; em_wdata = '0; em_raddr = '0;
        fm_we = 1'b0; fm_waddr = '0; fm_wdata = '0; fm_raddr = '0;
        sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0; sm_raddr = '0;
        km_we = 1'b0; km_waddr = '0; km_wdata = '0; km_raddr = '0;
        mm_req = '0;

        unique case (state_reg)
            S_INIT: begin
                fm_we      = 1'b1;
                fm_waddr   = sweep_reg;
                fm_wdata   = EMPTY;
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE: begin
                // head of the source list is read ahead for an add beat
                fm_raddr  = NIW'(s_from_node);
                from_next = NIW'(s_from_node);
                to_next   = NIW'(s_to_node);
                elen_next = mod_once((LEN_W+1)'(s_edge_length));
                sweep_next = '0;
                if (s_valid) begin
                    case (s_kind)
                        KIND_ADD: begin
                            if (from_ok && to_ok && store_full) ovf_next = 1'b1;
                        end
                        KIND_CLEAR: begin
                            fill_next = '0;
                            ovf_next  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_WR: begin
                em_we     = 1'b1;
                em_waddr  = EIW'(fill_reg);
                em_wdata  = {to_reg, elen_reg, fm_rdata};
                fm_we     = 1'b1;
                fm_waddr  = from_reg;
                fm_wdata  = fill_reg;
                fill_next = fill_reg + 1'b1;
            end
            S_CLR_NODE: begin
                sm_we      = 1'b1;
                sm_waddr   = sweep_reg;
                sm_wdata   = '0;
                sweep_next = sweep_reg + 1'b1;
                cnt_next   = '0;
            end
            S_CNT_RD: em_raddr = EIW'(cnt_reg);
            S_CNT_NODE: begin
                sm_raddr = ed_dest;
                y_next   = ed_dest;
            end
            S_CNT_WR: begin
                sm_we    = 1'b1;
                sm_waddr = y_reg;
                sm_wdata = {st_pend + 1'b1, st_paths, st_len};
                cnt_next = cnt_reg + 1'b1;
            end
            S_SEED_RD: begin
                sm_raddr = NIW'(start_reg);
                top_next = '0;
            end
            S_SEED_WR: begin
                sm_we    = 1'b1;
                sm_waddr = NIW'(start_reg);
                sm_wdata = {st_pend, LEN_W'(1), st_len};
                km_we    = 1'b1;
                km_waddr = '0;
                km_wdata = NIW'(start_reg);
                top_next = TW'(1);
            end
            S_POP: begin
                km_raddr = NIW'(top_reg - 1'b1);
                if (top_reg != '0) top_next = top_reg - 1'b1;
            end
            S_POP_WAIT: begin
                x_next   = km_rdata;
                fm_raddr = km_rdata;
            end
            S_FIRST: e_next = fm_rdata;
            S_EDGE_CHK: em_raddr = EIW'(e_reg);
            S_EDGE_DAT: begin
                y_next    = ed_dest;
                len_next  = ed_len;
                link_next = ed_link;
                sm_raddr  = x_reg;
            end
            S_XDAT: begin
                // source values re-read at every edge (self loops see updates)
                c_next   = st_paths;
                l_next   = st_len;
                sm_raddr = y_reg;
            end
            S_YDAT: begin
                ypend_next    = st_pend;
                ypath_next    = st_paths;
                mm_req.start  = 1'b1;
                mm_req.a      = c_reg;
                mm_req.b      = len_reg;
                mm_req.addend = (LEN_W+1)'(st_len) + (LEN_W+1)'(l_reg);
            end
            S_MUL: begin
                if (mm_done) begin
                    sm_we    = 1'b1;
                    sm_waddr = y_reg;
                    sm_wdata = {(ypend_reg == '0) ? ypend_reg : ypend_reg - 1'b1,
                                mod_once((LEN_W+1)'(ypath_reg) + (LEN_W+1)'(c_reg)),
                                mm_res};
                    // last pending predecessor done: successor is ready
                    if (ypend_reg == FW'(1) && stack_room) begin
                        km_we    = 1'b1;
                        km_waddr = NIW'(top_reg);
                        km_wdata = y_reg;
                        top_next = top_reg + 1'b1;
                    end
                    e_next = link_reg;
                end
            end
            S_ANS_RD: sm_raddr = NIW'(target_reg);
            S_ANS_GO: begin
                c_next = tgt_ok ? st_paths : '0;
                l_next = tgt_ok ? st_len : '0;
                mm_req.start  = 1'b1;
                mm_req.a      = tgt_ok && (st_paths != '0) ? st_paths - 1'b1
                                                           : LEN_W'(MODV - 1);
                mm_req.b      = mod_once((LEN_W+1)'(extra_reg));
                mm_req.addend = tgt_ok ? (LEN_W+1)'(st_len) : '0;
            end
            S_ANS_WAIT: ;
            S_ANS_HOLD: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    ans_next  = mm_res;
                    drop_next = ovf_reg;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            sweep_reg  <= '0;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            top_reg    <= '0;
            mv_reg     <= 1'b0;
            start_reg  <= '0;
            target_reg <= '0;
            extra_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            top_reg   <= top_next;
            mv_reg    <= mv_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_START:  start_reg  <= NODE_W'(cfg_data);
                    CFG_TARGET: target_reg <= NODE_W'(cfg_data);
                    CFG_EXTRA:  extra_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
        cnt_reg   <= cnt_next;
        e_reg     <= e_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        len_reg   <= len_next;
        link_reg  <= link_next;
        c_reg     <= c_next;
        l_reg     <= l_next;
        ypend_reg <= ypend_next;
        ypath_reg <= ypath_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        elen_reg  <= elen_next;
        ans_reg   <= ans_next;
        drop_reg  <= drop_next;
    end

    assign s_ready         = state_reg == S_IDLE;
    assign cfg_ready       = 1'b1;
    assign m_valid         = mv_reg;
    assign m_answer        = ans_reg;
    assign m_edges_dropped = drop_reg;

endmodule

// ----- rtl/dpc_checker.sv -----
// Port-level checks for dag_path_count_length_sum, attached by bind.
// Depends on dpc_pkg.
`timescale 1ns / 1ps

module dpc_checker
    import dpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [KIND_W-1:0]    s_kind,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [LEN_W-1:0]     m_answer,
    input logic                 m_edges_dropped
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_answer) && $stable(m_edges_dropped))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_answer < LEN_W'(MODV))
        else $error("answer not reduced");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_COMPUTE || s_kind == KIND_CLEAR) |=> !s_ready)
        else $error("item taken during a compute or clear");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channels active after reset");

endmodule

bind dag_path_count_length_sum dpc_checker u_dpc_checker (.*);

// ----- bench/dag_path_count_length_sum_tb.sv -----
// Self-checking bench for dag_path_count_length_sum: random graphs, path/length walk.
// Depends on dpc_pkg and the dag_path_count_length_sum RTL; no other files.
`timescale 1ns / 1ps

module dag_path_count_length_sum_tb;
    import dpc_pkg::*;

    localparam int NODES    = 1024;
    localparam int EDGES    = 4096;
    localparam int ITEMS    = 1550;
    localparam int SETTLE   = 1100;  // covers a clear pass after the last answer
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [LEN_W-1:0]  len;
    } graph_item_t;

    typedef struct {
        logic [LEN_W-1:0] answer;
        logic             dropped;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    logic [NODE_W-1:0] s_from_node = '0;
    logic [NODE_W-1:0] s_to_node = '0;
    logic [LEN_W-1:0]  s_edge_length = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [LEN_W-1:0]  m_answer;
    logic              m_edges_dropped;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    dag_path_count_length_sum dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_kind, .s_from_node, .s_to_node, .s_edge_length,
        .m_valid, .m_ready, .m_answer, .m_edges_dropped,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Graph mirror: edge store with per-node singly linked lists, plus the
    // three registers. Updated when a beat is accepted.
    // ------------------------------------------------------------------
    int unsigned edge_to[EDGES];
    int unsigned edge_wt[EDGES];
    int unsigned edge_next[EDGES];
    int unsigned node_head[NODES];
    int unsigned edge_count;
    bit          store_overflow;
    int unsigned reg_start, reg_target, reg_extra;

    graph_item_t pending_items[$];
    answer_t     expected_answers[$];
    int          mismatches = 0;
    int          s_idle_pct = 37;
    int          m_idle_pct = 37;

    function automatic void empty_graph();
        for (int i = 0; i < NODES; i++) node_head[i] = EDGES;
        edge_count = 0;
        store_overflow = 1'b0;
    endfunction

    // Counts paths from start and sums their lengths, all mod 10000, then
    // folds in the per-extra-path cost for the target node.
    function automatic logic [LEN_W-1:0] path_cost_sum();
        int unsigned preds[NODES];
        int unsigned npaths[NODES];
        int unsigned lsum[NODES];
        int unsigned stk[NODES];
        int unsigned top, x, y, e, c, l;
        for (int i = 0; i < NODES; i++) begin
            preds[i] = 0; npaths[i] = 0; lsum[i] = 0;
        end
        for (int i = 0; i < edge_count; i++) preds[edge_to[i]]++;
        top = 0;
        npaths[reg_start] = 1;
        stk[top] = reg_start;
        top++;
        while (top > 0) begin
            top--;
            x = stk[top];
            e = node_head[x];
            while (e < edge_count) begin
                y = edge_to[e];
                // self loops: source values are re-read per edge
                c = npaths[x];
                l = lsum[x];
                npaths[y] = (npaths[y] + c) % MODV;
                lsum[y] = (lsum[y] + l + c * edge_wt[e]) % MODV;
                if (preds[y] > 0) begin
                    preds[y]--;
                    if (preds[y] == 0 && top < NODES) begin
                        stk[top] = y;
                        top++;
                    end
                end
                e = edge_next[e];
            end
        end
        c = npaths[reg_target];
        l = lsum[reg_target];
        return LEN_W'((((c + MODV - 1) % MODV) * (reg_extra % MODV) + l) % MODV);
    endfunction

    function automatic void apply_item(graph_item_t it);
        answer_t a;
        case (it.kind)
            KIND_ADD: begin
                if (edge_count >= EDGES) begin
                    store_overflow = 1'b1;
                end else begin
                    edge_to[edge_count]   = it.dst;
                    edge_wt[edge_count]   = it.len % MODV;
                    edge_next[edge_count] = node_head[it.src];
                    node_head[it.src]     = edge_count;
                    edge_count++;
                end
            end
            KIND_COMPUTE: begin
                a.answer  = path_cost_sum();
                a.dropped = store_overflow;
                expected_answers.push_back(a);
            end
            KIND_CLEAR: empty_graph();
            default: ;  // unused kind: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item driver: one NBA per signal per edge; valid held until accepted.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        graph_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                apply_item('{s_kind, s_from_node, s_to_node, s_edge_length});
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                nxt = pending_items.pop_front();
                s_valid       <= 1'b1;
                s_kind        <= nxt.kind;
                s_from_node   <= nxt.src;
                s_to_node     <= nxt.dst;
                s_edge_length <= nxt.len;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure, every answer beat checked in order.
    always @(posedge aclk) begin
        answer_t exp_a;
        m_ready <= aresetn && ($urandom_range(99) >= m_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer beat: answer=%0d dropped=%0b",
                             m_answer, m_edges_dropped);
            end else begin
                exp_a = expected_answers.pop_front();
                if (m_answer !== exp_a.answer || m_edges_dropped !== exp_a.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer beat: expected %0d/%0b got %0d/%0b",
                                 exp_a.answer, exp_a.dropped, m_answer, m_edges_dropped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [KIND_W-1:0] k, int unsigned a,
                                       int unsigned b, int unsigned w);
        pending_items.push_back('{k, NODE_W'(a), NODE_W'(b), LEN_W'(w)});
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START:  reg_start  = val & 10'h3FF;
            CFG_TARGET: reg_target = val & 10'h3FF;
            CFG_EXTRA:  reg_extra  = val & 14'h3FFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(input int unsigned st, input int unsigned tg, input int unsigned xc);
        write_reg(CFG_START, st);
        write_reg(CFG_TARGET, tg);
        write_reg(CFG_EXTRA, xc);
    endtask

    // Block idle: all beats sent, all answers back, then room for a clear pass.
    task automatic drain();
        do @(posedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_answers.size() > 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int unsigned n, base, m, i, j, sent, phase, xc;
        empty_graph();
        reg_start = 0; reg_target = 0; reg_extra = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty graph, extremes of fields, self loop, unused kind, clear
        set_regs(0, 3, 9999);
        queue_item(KIND_COMPUTE, 0, 0, 0);          // no path to target
        queue_item(KIND_ADD, 0, 1, 16383);
        queue_item(KIND_ADD, 0, 2, 0);
        queue_item(KIND_ADD, 1, 3, 9999);
        queue_item(KIND_ADD, 2, 3, 1);
        queue_item(KIND_ADD, 1, 2, 5000);
        queue_item(KIND_UNUSED, 1023, 1023, 16383);
        queue_item(KIND_ADD, 1023, 0, 7);
        queue_item(KIND_ADD, 3, 1023, 8191);
        queue_item(KIND_COMPUTE, 0, 0, 0);
        queue_item(KIND_COMPUTE, 1023, 1023, 16383); // repeat gives same answer
        queue_item(KIND_ADD, 3, 3, 10000);           // self loop
        queue_item(KIND_COMPUTE, 0, 0, 0);
        queue_item(KIND_CLEAR, 0, 0, 0);
        queue_item(KIND_COMPUTE, 0, 0, 0);
        drain();
        set_regs(1023, 1023, 0);                     // start equals target
        queue_item(KIND_ADD, 1023, 0, 1);
        queue_item(KIND_COMPUTE, 0, 0, 0);
        drain();

        // random phases of acyclic graphs on a window of nodes, some noise
        sent = 0;
        phase = 0;
        while (sent < ITEMS) begin
            s_idle_pct = (phase >= 8 && phase < 14) ? 0 : 37;
            m_idle_pct = s_idle_pct;
            n    = ($urandom_range(9) == 0) ? 200 : $urandom_range(2, 24);
            base = ($urandom_range(5) == 0) ? 1024 - n : $urandom_range(0, 1024 - n);
            case ($urandom_range(2))
                0: xc = 0;
                1: xc = 9999;
                default: xc = $urandom_range(0, 9999);
            endcase
            set_regs(($urandom_range(9) == 0) ? $urandom_range(0, 1023) : base,
                     ($urandom_range(4) == 0) ? base + $urandom_range(0, n - 1) : base + n - 1,
                     xc);
            if ($urandom_range(99) < 70 || edge_count > 3000) begin
                queue_item(KIND_CLEAR, 0, 0, 0);
                sent++;
            end
            m = $urandom_range(n, 3 * n);
            if (m > 80) m = 80;
            for (int k = 0; k < m; k++) begin
                case ($urandom_range(24))
                    0: queue_item(KIND_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(0, 16383));
                    1: queue_item(KIND_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(0, 16383));
                    2: queue_item(KIND_COMPUTE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(0, 16383));
                    default: begin
                        i = $urandom_range(0, n - 2);
                        j = $urandom_range(i + 1, n - 1);
                        queue_item(KIND_ADD, base + i, base + j, $urandom_range(0, 16383));
                    end
                endcase
                sent++;
            end
            queue_item(KIND_COMPUTE, 0, 0, 0);
            sent++;
            phase++;
            drain();
        end

        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("dag_path_count_length_sum: match");
        end else begin
            $display("dag_path_count_length_sum: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #300_000_000;
        $display("dag_path_count_length_sum: mismatch");
        $finish;
    end

endmodule
